// ===== rtl/owtr_pkg.sv =====
// shared types, constants and helpers for the one-wire temperature reader
package owtr_pkg;

  localparam int TIMER_W = 20;
  localparam int POLL_W = 4;
  localparam int CFG_ADDR_W = 3;
  localparam int TEMP_W = 16;

  localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_RESET_LOW    = 3'd0,
    REG_POLL_TICKS   = 3'd1,
    REG_POLLS        = 3'd2,
    REG_WRITE_SLOT   = 3'd3,
    REG_READ_SAMPLE  = 3'd4,
    REG_READ_RECOVER = 3'd5,
    REG_SETTLE       = 3'd6,
    REG_CONVERT      = 3'd7
  } reg_idx_t;

  typedef enum logic [4:0] {
    PH_IDLE        = 5'd0,
    PH_RST_LOW     = 5'd1,
    PH_PRES_SAMPLE = 5'd2,
    PH_PRES_WAIT   = 5'd3,
    PH_SETTLE      = 5'd4,
    PH_WR_START    = 5'd5,
    PH_WR_HOLD     = 5'd6,
    PH_WR_REL      = 5'd7,
    PH_CONVERT     = 5'd8,
    PH_RD_START    = 5'd9,
    PH_RD_WAIT     = 5'd10,
    PH_RD_REC      = 5'd11
  } phase_t;

  localparam logic [2:0] STEP_SKIP_1  = 3'd0;
  localparam logic [2:0] STEP_CONVERT = 3'd1;
  localparam logic [2:0] STEP_SKIP_2  = 3'd2;
  localparam logic [2:0] STEP_READ_SP = 3'd3;
  localparam logic [2:0] STEP_RD_LO   = 3'd4;
  localparam logic [2:0] STEP_RD_HI   = 3'd5;

  localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
  localparam logic [7:0] CMD_CONVERT  = 8'h44;
  localparam logic [7:0] CMD_READ_SP  = 8'hBE;

  typedef struct packed {
    logic cmd;
    logic bus_level;
  } item_t;

  typedef struct packed {
    logic [TIMER_W-1:0] reset_low_ticks;
    logic [TIMER_W-1:0] presence_poll_ticks;
    logic [POLL_W-1:0]  presence_polls;
    logic [TIMER_W-1:0] write_slot_ticks;
    logic [TIMER_W-1:0] read_sample_ticks;
    logic [TIMER_W-1:0] read_recover_ticks;
    logic [TIMER_W-1:0] settle_ticks;
    logic [TIMER_W-1:0] convert_ticks;
  } cfg_t;

  function automatic logic write_bit(input logic [2:0] byte_step, input logic [2:0] bit_index);
    logic [7:0] b;
    case (byte_step[1:0])
      2'd0:    b = CMD_SKIP_ROM;
      2'd1:    b = CMD_CONVERT;
      2'd2:    b = CMD_SKIP_ROM;
      default: b = CMD_READ_SP;
    endcase
    return b[bit_index];
  endfunction

endpackage

// ===== rtl/owtr_regs.sv =====
// configuration register bank
module owtr_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [owtr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [owtr_pkg::TIMER_W-1:0]      cfg_data,
  output owtr_pkg::cfg_t                    cfg
);

  owtr_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_ticks     <= owtr_pkg::TIMER_W'(700);
      cfg_r.presence_poll_ticks <= owtr_pkg::TIMER_W'(15);
      cfg_r.presence_polls      <= owtr_pkg::POLL_W'(5);
      cfg_r.write_slot_ticks    <= owtr_pkg::TIMER_W'(70);
      cfg_r.read_sample_ticks   <= owtr_pkg::TIMER_W'(2);
      cfg_r.read_recover_ticks  <= owtr_pkg::TIMER_W'(45);
      cfg_r.settle_ticks        <= owtr_pkg::TIMER_W'(1000);
      cfg_r.convert_ticks       <= owtr_pkg::TIMER_W'(750000);
    end else if (cfg_valid) begin
      unique case (owtr_pkg::reg_idx_t'(cfg_addr))
        owtr_pkg::REG_RESET_LOW:    cfg_r.reset_low_ticks     <= cfg_data;
        owtr_pkg::REG_POLL_TICKS:   cfg_r.presence_poll_ticks <= cfg_data;
        owtr_pkg::REG_POLLS:        cfg_r.presence_polls      <= cfg_data[owtr_pkg::POLL_W-1:0];
        owtr_pkg::REG_WRITE_SLOT:   cfg_r.write_slot_ticks    <= cfg_data;
        owtr_pkg::REG_READ_SAMPLE:  cfg_r.read_sample_ticks   <= cfg_data;
        owtr_pkg::REG_READ_RECOVER: cfg_r.read_recover_ticks  <= cfg_data;
        owtr_pkg::REG_SETTLE:       cfg_r.settle_ticks        <= cfg_data;
        owtr_pkg::REG_CONVERT:      cfg_r.convert_ticks       <= cfg_data;
        default:                    cfg_r <= cfg_r;
      endcase
    end
  end

endmodule

// ===== rtl/owtr_front.sv =====
// input side: accepts ticks into a two-entry queue
module owtr_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  owtr_pkg::item_t in_item,
  output logic            q_valid,
  input  logic            q_pop,
  output owtr_pkg::item_t q_item
);

  owtr_pkg::item_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  logic       pop;

  assign in_tready = (count_r != 2'd2);
  assign q_valid   = (count_r != 2'd0);
  assign q_item    = mem_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n) count_r <= 2'd2)
    else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0) |=> (count_r <= 2'd1))
    else $error("queue drained below empty");
  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd2 && !q_pop) |=> (count_r == 2'd2))
    else $error("queue lost an entry");

endmodule

// ===== rtl/owtr_back.sv =====
// bus sequencer and result register
module owtr_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  owtr_pkg::cfg_t                cfg,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  owtr_pkg::item_t               q_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_drive,
  output logic                          out_busy,
  output logic                          out_missing,
  output logic [owtr_pkg::TEMP_W-1:0]   out_temp,
  output logic                          out_temp_valid
);

  owtr_pkg::phase_t phase_r, phase_nxt;
  logic [owtr_pkg::TIMER_W-1:0] timer_r, timer_nxt;
  logic [owtr_pkg::POLL_W-1:0]  poll_r, poll_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [2:0]  byte_r, byte_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [owtr_pkg::TEMP_W-1:0] reading_r, reading_nxt;
  logic        missing_r, missing_nxt;
  logic        valid_nxt;
  logic        drive_nxt;

  logic [owtr_pkg::TIMER_W-1:0] limit;
  logic        timed;
  logic        done;
  logic        step;

  logic        out_valid_r;
  logic        out_drive_r;
  logic        out_busy_r;
  logic        out_missing_r;
  logic [owtr_pkg::TEMP_W-1:0] out_temp_r;
  logic        out_temp_valid_r;

  assign q_pop = !out_valid_r || out_ready;
  assign step  = q_pop && q_valid;

  always_comb begin
    timed = 1'b1;
    case (phase_r)
      owtr_pkg::PH_RST_LOW:   limit = cfg.reset_low_ticks;
      owtr_pkg::PH_PRES_WAIT: limit = cfg.presence_poll_ticks;
      owtr_pkg::PH_WR_HOLD:   limit = cfg.write_slot_ticks;
      owtr_pkg::PH_RD_WAIT:   limit = cfg.read_sample_ticks;
      owtr_pkg::PH_RD_REC:    limit = cfg.read_recover_ticks;
      owtr_pkg::PH_SETTLE:    limit = cfg.settle_ticks;
      owtr_pkg::PH_CONVERT:   limit = cfg.convert_ticks;
      default: begin
        limit = '0;
        timed = 1'b0;
      end
    endcase
    done = (({1'b0, timer_r} + 1'b1) >= {1'b0, limit}) || (timer_r == owtr_pkg::TIMER_MAX);
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      owtr_pkg::PH_IDLE:
        if (q_item.cmd) phase_nxt = owtr_pkg::PH_RST_LOW;
      owtr_pkg::PH_RST_LOW:
        if (done) phase_nxt = owtr_pkg::PH_PRES_SAMPLE;
      owtr_pkg::PH_PRES_SAMPLE:
        if (!q_item.bus_level || poll_r >= cfg.presence_polls) begin
          phase_nxt = owtr_pkg::PH_SETTLE;
        end else begin
          phase_nxt = owtr_pkg::PH_PRES_WAIT;
        end
      owtr_pkg::PH_PRES_WAIT:
        if (done) phase_nxt = owtr_pkg::PH_PRES_SAMPLE;
      owtr_pkg::PH_SETTLE:
        if (done) phase_nxt = owtr_pkg::PH_WR_START;
      owtr_pkg::PH_WR_START:
        phase_nxt = owtr_pkg::PH_WR_HOLD;
      owtr_pkg::PH_WR_HOLD:
        if (done) phase_nxt = owtr_pkg::PH_WR_REL;
      owtr_pkg::PH_WR_REL:
        if (bit_r != 3'd7) begin
          phase_nxt = owtr_pkg::PH_WR_START;
        end else if (byte_r == owtr_pkg::STEP_SKIP_1 || byte_r == owtr_pkg::STEP_SKIP_2) begin
          phase_nxt = owtr_pkg::PH_WR_START;
        end else if (byte_r == owtr_pkg::STEP_CONVERT) begin
          phase_nxt = owtr_pkg::PH_CONVERT;
        end else begin
          phase_nxt = owtr_pkg::PH_RD_START;
        end
      owtr_pkg::PH_CONVERT:
        if (done) phase_nxt = owtr_pkg::PH_RST_LOW;
      owtr_pkg::PH_RD_START:
        phase_nxt = owtr_pkg::PH_RD_WAIT;
      owtr_pkg::PH_RD_WAIT:
        if (done) phase_nxt = owtr_pkg::PH_RD_REC;
      owtr_pkg::PH_RD_REC:
        if (done) begin
          if (bit_r != 3'd7 || byte_r == owtr_pkg::STEP_RD_LO) begin
            phase_nxt = owtr_pkg::PH_RD_START;
          end else begin
            phase_nxt = owtr_pkg::PH_IDLE;
          end
        end
      default:
        phase_nxt = owtr_pkg::PH_IDLE;
    endcase
  end

  // datapath registers
  always_comb begin
    timer_nxt   = (timed && !done) ? timer_r + 1'b1 : '0;
    poll_nxt    = poll_r;
    bit_nxt     = bit_r;
    byte_nxt    = byte_r;
    shift_nxt   = shift_r;
    reading_nxt = reading_r;
    missing_nxt = missing_r;
    valid_nxt   = 1'b0;
    unique case (phase_r)
      owtr_pkg::PH_IDLE:
        if (q_item.cmd) begin
          missing_nxt = 1'b0;
          byte_nxt    = owtr_pkg::STEP_SKIP_1;
          bit_nxt     = 3'd0;
          poll_nxt    = '0;
        end
      owtr_pkg::PH_RST_LOW:
        if (done) poll_nxt = '0;
      owtr_pkg::PH_PRES_SAMPLE:
        if (q_item.bus_level) begin
          if (poll_r >= cfg.presence_polls) begin
            missing_nxt = 1'b1;
          end else begin
            poll_nxt = poll_r + 1'b1;
          end
        end
      owtr_pkg::PH_SETTLE:
        if (done) bit_nxt = 3'd0;
      owtr_pkg::PH_WR_REL:
        if (bit_r != 3'd7) begin
          bit_nxt = bit_r + 3'd1;
        end else begin
          bit_nxt = 3'd0;
          if (byte_r == owtr_pkg::STEP_SKIP_1 || byte_r == owtr_pkg::STEP_SKIP_2) begin
            byte_nxt = byte_r + 3'd1;
          end else if (byte_r != owtr_pkg::STEP_CONVERT) begin
            byte_nxt  = owtr_pkg::STEP_RD_LO;
            shift_nxt = 8'd0;
          end
        end
      owtr_pkg::PH_CONVERT:
        if (done) byte_nxt = owtr_pkg::STEP_SKIP_2;
      owtr_pkg::PH_RD_WAIT:
        if (done) shift_nxt = shift_r | (8'(q_item.bus_level) << bit_r);
      owtr_pkg::PH_RD_REC:
        if (done) begin
          if (bit_r != 3'd7) begin
            bit_nxt = bit_r + 3'd1;
          end else if (byte_r == owtr_pkg::STEP_RD_LO) begin
            reading_nxt = {reading_r[15:8], shift_r};
            byte_nxt    = owtr_pkg::STEP_RD_HI;
            bit_nxt     = 3'd0;
            shift_nxt   = 8'd0;
          end else begin
            reading_nxt = {shift_r, reading_r[7:0]};
            byte_nxt    = owtr_pkg::STEP_SKIP_1;
            bit_nxt     = 3'd0;
            valid_nxt   = 1'b1;
          end
        end
      default: ;
    endcase
  end

  // line drive for the phase being entered
  always_comb begin
    unique case (phase_nxt)
      owtr_pkg::PH_RST_LOW, owtr_pkg::PH_WR_START, owtr_pkg::PH_RD_START:
        drive_nxt = 1'b1;
      owtr_pkg::PH_WR_HOLD:
        drive_nxt = ~owtr_pkg::write_bit(byte_nxt, bit_nxt);
      default:
        drive_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= owtr_pkg::PH_IDLE;
      timer_r   <= '0;
      poll_r    <= '0;
      bit_r     <= 3'd0;
      byte_r    <= 3'd0;
      shift_r   <= 8'd0;
      reading_r <= '0;
      missing_r <= 1'b0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      timer_r   <= timer_nxt;
      poll_r    <= poll_nxt;
      bit_r     <= bit_nxt;
      byte_r    <= byte_nxt;
      shift_r   <= shift_nxt;
      reading_r <= reading_nxt;
      missing_r <= missing_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_drive_r      <= drive_nxt;
      out_busy_r       <= (phase_nxt != owtr_pkg::PH_IDLE);
      out_missing_r    <= missing_nxt;
      out_temp_r       <= reading_nxt;
      out_temp_valid_r <= valid_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_drive      = out_drive_r;
  assign out_busy       = out_busy_r;
  assign out_missing    = out_missing_r;
  assign out_temp       = out_temp_r;
  assign out_temp_valid = out_temp_valid_r;

  a_idle_timer: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == owtr_pkg::PH_IDLE) |-> (timer_r == '0))
    else $error("timer running while idle");
  a_byte_step: assert property (@(posedge clk) disable iff (!rst_n)
    byte_r <= owtr_pkg::STEP_RD_HI)
    else $error("byte step out of range");
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_temp_valid_r) |-> (!out_busy_r && phase_r == owtr_pkg::PH_IDLE))
    else $error("reading flagged while sequence still running");
  a_step_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !step)
    else $error("result register overwritten while stalled");

endmodule

// ===== rtl/onewire_temperature_reader.sv =====
// top level of the one-wire temperature reader
//
//  channel | dir | handshake             | payload
//  in_     | in  | in_tvalid/in_tready   | tuser: cmd; tdata: bus_level
//  out_    | out | out_tvalid/out_tready | tdata: drive, busy, missing, temp, valid
//  cfg_    | in  | cfg_valid/cfg_ready   | cfg_addr register index, cfg_data value
//
//  one tick is taken per cycle while the tick queue has room; the sequencer steps on the tick
//  at the queue head, and its result is registered when the sequencer takes it from there;
//  a two-entry tick queue and the result register let either side stall alone
//  synchronous active-low reset restores register defaults and idles the sequencer; drive is not reset
module onewire_temperature_reader (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [0] bus_level
  input  logic                             in_tuser,   // [0] cmd
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [23:0]                      out_tdata,  // [0] bus_drive_low, [1] busy_res,
                                                       // [2] presence_missing,
                                                       // [18:3] temperature, [19] temp_valid
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [owtr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [owtr_pkg::TIMER_W-1:0]     cfg_data
);

  owtr_pkg::cfg_t  cfg;
  owtr_pkg::item_t in_item;
  owtr_pkg::item_t q_item;
  logic            q_valid;
  logic            q_pop;
  logic            drive;
  logic            busy;
  logic            missing;
  logic [owtr_pkg::TEMP_W-1:0] temp;
  logic            temp_valid;

  assign in_item.cmd       = in_tuser;
  assign in_item.bus_level = in_tdata[0];

  owtr_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  owtr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_item   (in_item),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item)
  );

  owtr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_item         (q_item),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_drive      (drive),
    .out_busy       (busy),
    .out_missing    (missing),
    .out_temp       (temp),
    .out_temp_valid (temp_valid)
  );

  assign out_tdata = {4'd0, temp_valid, temp, missing, busy, drive};

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// testbench for the one-wire temperature reader: random line ticks checked against a tick model
module tb;
  import owtr_pkg::*;

  typedef struct packed {
    logic              drive;
    logic              busy;
    logic              missing;
    logic [TEMP_W-1:0] temp;
    logic              valid;
  } reading_t;

  typedef enum {PROF_TIGHT, PROF_MEDIUM, PROF_PRESENCE, PROF_MAX} profile_t;

  // command bytes in send order from the low byte up, one byte per step
  localparam logic [31:0] CMD_SEQ = {CMD_READ_SP, CMD_SKIP_ROM, CMD_CONVERT, CMD_SKIP_ROM};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = 8'd0;   // [0] bus_level
  logic                  in_tuser = 1'b0;   // [0] cmd
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [23:0]           out_tdata;         // [0] drive, [1] busy, [2] missing,
                                            // [18:3] temp, [19] valid
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [TIMER_W-1:0]    cfg_data = '0;

  onewire_temperature_reader uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  item_t    tick_q[$];
  reading_t reading_q[$];
  int       fail_cnt = 0;

  // model state
  logic [TIMER_W-1:0] tick_cfg [8];
  phase_t             seq_phase = PH_IDLE;
  logic [TIMER_W-1:0] tmr = '0;
  logic [POLL_W-1:0]  polls_used = '0;
  logic [2:0]         bit_idx = '0;
  logic [2:0]         byte_step = '0;
  logic [7:0]         shift_reg = '0;
  logic [TEMP_W-1:0]  temp_reg = '0;
  logic               missing_f = 1'b0;

  function automatic void go(input phase_t p);
    seq_phase = p;
    tmr = '0;
  endfunction

  function automatic logic slot_done(input logic [TIMER_W-1:0] n);
    if ({1'b0, tmr} + 21'd1 >= {1'b0, n} || tmr == TIMER_MAX) begin
      tmr = '0;
      return 1'b1;
    end
    tmr = tmr + 1'b1;
    return 1'b0;
  endfunction

  function automatic reading_t advance_reader(input item_t it);
    reading_t r;
    r = '0;
    case (seq_phase)
      PH_IDLE: begin
        if (it.cmd) begin
          missing_f = 1'b0;
          byte_step = STEP_SKIP_1;
          bit_idx = '0;
          polls_used = '0;
          go(PH_RST_LOW);
        end
      end
      PH_RST_LOW: begin
        if (slot_done(tick_cfg[REG_RESET_LOW])) begin
          polls_used = '0;
          go(PH_PRES_SAMPLE);
        end
      end
      PH_PRES_SAMPLE: begin
        if (!it.bus_level) begin
          go(PH_SETTLE);
        end else if (polls_used >= tick_cfg[REG_POLLS][POLL_W-1:0]) begin
          missing_f = 1'b1;
          go(PH_SETTLE);
        end else begin
          polls_used = polls_used + 1'b1;
          go(PH_PRES_WAIT);
        end
      end
      PH_PRES_WAIT: begin
        if (slot_done(tick_cfg[REG_POLL_TICKS])) go(PH_PRES_SAMPLE);
      end
      PH_SETTLE: begin
        if (slot_done(tick_cfg[REG_SETTLE])) begin
          bit_idx = '0;
          go(PH_WR_START);
        end
      end
      PH_WR_START: go(PH_WR_HOLD);
      PH_WR_HOLD: begin
        if (slot_done(tick_cfg[REG_WRITE_SLOT])) go(PH_WR_REL);
      end
      PH_WR_REL: begin
        if (bit_idx != 3'd7) begin
          bit_idx = bit_idx + 1'b1;
          go(PH_WR_START);
        end else begin
          bit_idx = '0;
          if (byte_step == STEP_SKIP_1 || byte_step == STEP_SKIP_2) begin
            byte_step = byte_step + 1'b1;
            go(PH_WR_START);
          end else if (byte_step == STEP_CONVERT) begin
            go(PH_CONVERT);
          end else begin
            byte_step = STEP_RD_LO;
            shift_reg = '0;
            go(PH_RD_START);
          end
        end
      end
      PH_CONVERT: begin
        if (slot_done(tick_cfg[REG_CONVERT])) begin
          byte_step = STEP_SKIP_2;
          go(PH_RST_LOW);
        end
      end
      PH_RD_START: go(PH_RD_WAIT);
      PH_RD_WAIT: begin
        if (slot_done(tick_cfg[REG_READ_SAMPLE])) begin
          shift_reg = shift_reg | (8'(it.bus_level) << bit_idx);
          go(PH_RD_REC);
        end
      end
      PH_RD_REC: begin
        if (slot_done(tick_cfg[REG_READ_RECOVER])) begin
          if (bit_idx != 3'd7) begin
            bit_idx = bit_idx + 1'b1;
            go(PH_RD_START);
          end else if (byte_step == STEP_RD_LO) begin
            temp_reg[7:0] = shift_reg;
            byte_step = STEP_RD_HI;
            bit_idx = '0;
            shift_reg = '0;
            go(PH_RD_START);
          end else begin
            temp_reg[15:8] = shift_reg;
            byte_step = STEP_SKIP_1;
            bit_idx = '0;
            r.valid = 1'b1;
            go(PH_IDLE);
          end
        end
      end
      default: go(PH_IDLE);
    endcase

    case (seq_phase)
      PH_RST_LOW, PH_WR_START, PH_RD_START: r.drive = 1'b1;
      PH_WR_HOLD: r.drive = ~CMD_SEQ[{byte_step[1:0], bit_idx}];
      default: r.drive = 1'b0;
    endcase
    r.busy = (seq_phase != PH_IDLE);
    r.missing = missing_f;
    r.temp = temp_reg;
    return r;
  endfunction

  // sender: bursts of ticks with random gaps
  int    burst_left = 0;
  int    gap_left = 0;
  item_t next_tick;
  item_t taken_tick;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        taken_tick.cmd = in_tuser;
        taken_tick.bus_level = in_tdata[0];
        reading_q.push_back(advance_reader(taken_tick));
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          next_tick = tick_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {7'd0, next_tick.bus_level};
          in_tuser <= next_tick.cmd;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 48);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end else begin
            burst_left--;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: rotating stall pattern, renewed whenever its age counter wraps
  logic [15:0] rdy_pat = 16'hFFFF;
  logic [5:0]  pat_age = '0;
  reading_t    want;
  reading_t    seen;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen.drive = out_tdata[0];
        seen.busy = out_tdata[1];
        seen.missing = out_tdata[2];
        seen.temp = out_tdata[18:3];
        seen.valid = out_tdata[19];
        if (reading_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) $display("result with nothing pending: %h", out_tdata);
        end else begin
          want = reading_q.pop_front();
          if (seen.drive !== want.drive || seen.busy !== want.busy ||
              seen.missing !== want.missing || seen.temp !== want.temp ||
              seen.valid !== want.valid) begin
            fail_cnt++;
            if (fail_cnt <= 10) begin
              $display("mismatch: expected drv %b busy %b miss %b temp %0d vld %b",
                       want.drive, want.busy, want.missing, $signed(want.temp), want.valid);
              $display("          got      drv %b busy %b miss %b temp %0d vld %b",
                       seen.drive, seen.busy, seen.missing, $signed(seen.temp), seen.valid);
            end
          end
        end
      end
      if (pat_age == 0)
        rdy_pat = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      else
        rdy_pat = {rdy_pat[0], rdy_pat[15:1]};
      pat_age = pat_age + 1'b1;
      out_tready <= rdy_pat[0];
    end
  end

  task automatic push_tick(input logic cmd, input logic level);
    item_t t;
    t.cmd = cmd;
    t.bus_level = level;
    tick_q.push_back(t);
  endtask

  task automatic random_ticks(input int n, input int high_pct);
    item_t t;
    repeat (n) begin
      t.cmd = ($urandom_range(0, 99) < 8);
      t.bus_level = ($urandom_range(0, 99) < high_pct);
      tick_q.push_back(t);
    end
  endtask

  task automatic drain();
    while (tick_q.size() != 0 || in_tvalid || reading_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [TIMER_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tick_cfg[idx] = (idx == REG_POLLS) ? {{(TIMER_W-POLL_W){1'b0}}, val[POLL_W-1:0]} : val;
  endtask

  task automatic load_profile(input profile_t prof);
    logic [TIMER_W-1:0] v;
    for (int i = 0; i < 8; i++) begin
      case (prof)
        PROF_TIGHT: v = 20'($urandom_range(0, 2));
        PROF_MEDIUM: v = 20'($urandom_range(1, (i == REG_CONVERT) ? 30 : 8));
        PROF_PRESENCE: v = 20'($urandom_range(0, 2));
        default: v = TIMER_MAX;
      endcase
      if (i == REG_POLLS)
        v = (prof == PROF_PRESENCE || prof == PROF_MAX) ? 20'd15 : 20'($urandom_range(0, 15));
      write_reg(reg_idx_t'(i), v);
    end
  endtask

  initial begin
    profile_t prof;
    tick_cfg[REG_RESET_LOW] = 20'd700;
    tick_cfg[REG_POLL_TICKS] = 20'd15;
    tick_cfg[REG_POLLS] = 20'd5;
    tick_cfg[REG_WRITE_SLOT] = 20'd70;
    tick_cfg[REG_READ_SAMPLE] = 20'd2;
    tick_cfg[REG_READ_RECOVER] = 20'd45;
    tick_cfg[REG_SETTLE] = 20'd1000;
    tick_cfg[REG_CONVERT] = 20'd750000;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle ticks, a start, then a start while busy
    push_tick(1'b0, 1'b0);
    push_tick(1'b0, 1'b1);
    push_tick(1'b1, 1'b1);
    push_tick(1'b1, 1'b0);
    repeat (4) push_tick(1'b0, 1'b1);
    drain();

    // all counts zero, no presence polls: a high sample means no sensor
    for (int i = 0; i < 8; i++) write_reg(reg_idx_t'(i), '0);
    repeat (6) push_tick(1'b0, 1'b1);
    push_tick(1'b1, 1'b1);
    repeat (5) push_tick(1'b0, 1'b0);

    for (int r = 0; r < 10; r++) begin
      prof = profile_t'(r % 4);
      drain();
      load_profile(prof);
      random_ticks((prof == PROF_MAX) ? 40 : 230, (prof == PROF_PRESENCE) ? 85 : 50);
    end
    drain();
    repeat (20) @(posedge clk);

    if (fail_cnt == 0 && reading_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== onewire_temperature_reader.f =====
rtl/owtr_pkg.sv
rtl/owtr_regs.sv
rtl/owtr_front.sv
rtl/owtr_back.sv
rtl/onewire_temperature_reader.sv
dv/tb.sv
